>>> sv/scmpg_pkg.sv
package scmpg_pkg;

    // Field widths of the register file and of one sample
    localparam int POS_W     = 48;
    localparam int VEL_W     = 40;
    localparam int ACC_W     = 32;
    localparam int MAG_W     = 31;
    localparam int DUR_W     = 20;
    localparam int PROD_W    = MAG_W + DUR_W;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 3;

    // Defaults for the top level parameters
    localparam int TICK_BITS_DEF = 20;
    localparam int POS_BITS_DEF  = 48;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_POS   = 3'd0,
        CFG_END_POS     = 3'd1,
        CFG_PEAK_ACCEL  = 3'd2,
        CFG_JERK_STEP   = 3'd3,
        CFG_RAMP_TICKS  = 3'd4,
        CFG_HOLD_TICKS  = 3'd5,
        CFG_TOTAL_TICKS = 3'd6
    } t_cfg_idx;

    // Segments of the seven-segment profile
    typedef enum logic [PHASE_W-1:0] {
        PH_JERK_UP     = 3'd0,
        PH_ACCEL_HOLD  = 3'd1,
        PH_JERK_DOWN   = 3'd2,
        PH_CRUISE      = 3'd3,
        PH_DECEL_UP    = 3'd4,
        PH_DECEL_HOLD  = 3'd5,
        PH_DECEL_DOWN  = 3'd6
    } t_phase;

    typedef struct packed {
        logic signed [POS_W-1:0] start_position;
        logic signed [POS_W-1:0] end_position;
        logic [MAG_W-1:0]        peak_accel;
        logic [MAG_W-1:0]        jerk_step;
        logic [DUR_W-1:0]        ramp_ticks;
        logic [DUR_W-1:0]        hold_ticks;
        logic [DUR_W-1:0]        total_ticks;
    } t_cfg;

    // Per-sample bookkeeping that rides along the pipeline
    typedef struct packed {
        logic             restart;
        logic [DUR_W-1:0] tick_index;
        t_phase           phase;
        logic             past_end;
        logic             last;
    } t_meta;

    typedef struct packed {
        t_meta            meta;
        logic [DUR_W-1:0] dt;
    } t_seg;

    typedef struct packed {
        t_meta                   meta;
        logic signed [ACC_W-1:0] accel;
    } t_acc;

endpackage

>>> sv/scmpg_cfg.sv
module scmpg_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [scmpg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scmpg_pkg::POS_W-1:0]          i_cfg_data,
    output logic                                 o_cfg_ready,
    output scmpg_pkg::t_cfg                      o_cfg
);

    scmpg_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write one register per transaction, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                start_position: '0,
                end_position:   '0,
                peak_accel:     '0,
                jerk_step:      '0,
                ramp_ticks:     '0,
                hold_ticks:     '0,
                total_ticks:    scmpg_pkg::DUR_W'(1)
            };
        end else if (i_cfg_valid) begin
            unique case (scmpg_pkg::t_cfg_idx'(i_cfg_index))
                scmpg_pkg::CFG_START_POS:   r_cfg.start_position <= i_cfg_data;
                scmpg_pkg::CFG_END_POS:     r_cfg.end_position   <= i_cfg_data;
                scmpg_pkg::CFG_PEAK_ACCEL:
                    r_cfg.peak_accel  <= i_cfg_data[scmpg_pkg::MAG_W-1:0];
                scmpg_pkg::CFG_JERK_STEP:
                    r_cfg.jerk_step   <= i_cfg_data[scmpg_pkg::MAG_W-1:0];
                scmpg_pkg::CFG_RAMP_TICKS:
                    r_cfg.ramp_ticks  <= i_cfg_data[scmpg_pkg::DUR_W-1:0];
                scmpg_pkg::CFG_HOLD_TICKS:
                    r_cfg.hold_ticks  <= i_cfg_data[scmpg_pkg::DUR_W-1:0];
                scmpg_pkg::CFG_TOTAL_TICKS:
                    r_cfg.total_ticks <= i_cfg_data[scmpg_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> sv/scmpg_seg.sv
module scmpg_seg #(
    parameter int TICK_BITS = scmpg_pkg::TICK_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scmpg_pkg::t_cfg i_cfg,
    input  logic            i_valid,
    input  logic            i_restart,
    input  logic            i_ready_next,
    output logic            o_ready,
    output logic            o_valid,
    output scmpg_pkg::t_seg o_seg
);

    // Signed width that holds the tick and every segment bound
    localparam int CW = ((TICK_BITS > scmpg_pkg::DUR_W + 2) ?
                         TICK_BITS : scmpg_pkg::DUR_W + 2) + 2;

    logic [TICK_BITS-1:0] r_tick;
    logic [TICK_BITS-1:0] n_tick;
    logic [TICK_BITS-1:0] w_t;
    logic                 r_valid;
    scmpg_pkg::t_seg      r_seg;
    scmpg_pkg::t_seg      n_seg;
    logic                 w_load;
    logic signed [CW-1:0] w_ts;
    logic signed [CW-1:0] w_r;
    logic signed [CW-1:0] w_h;
    logic signed [CW-1:0] w_tt;
    logic signed [CW-1:0] w_tb;
    logic signed [CW-1:0] w_tc;
    logic signed [CW-1:0] w_td;
    logic signed [CW-1:0] w_te;
    logic signed [CW-1:0] w_tg;
    logic signed [CW-1:0] w_base;
    logic signed [CW-1:0] w_dt;

    assign o_ready = !r_valid || i_ready_next;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_seg   = r_seg;

    // Restart drops back to tick zero; the counter holds at its top value
    assign w_t    = i_restart ? '0 : r_tick;
    assign n_tick = (w_t == '1) ? w_t : w_t + TICK_BITS'(1);

    // Segment bounds and decode, earlier segments win on overlap
    always_comb begin
        w_ts = CW'(w_t);
        w_r  = CW'(i_cfg.ramp_ticks);
        w_h  = CW'(i_cfg.hold_ticks);
        w_tt = CW'(i_cfg.total_ticks);
        w_tb = w_r + w_h;
        w_tc = w_tb + w_r;
        w_td = w_tt - w_tc;
        w_te = w_tt - w_tb;
        w_tg = w_tt - w_r;

        n_seg.meta.restart    = i_restart;
        n_seg.meta.tick_index = scmpg_pkg::DUR_W'(w_t);
        n_seg.meta.past_end   = (w_ts >= w_tt);
        n_seg.meta.last       = (i_cfg.total_ticks != '0) && (w_ts == w_tt - CW'(1));

        priority if (n_seg.meta.past_end) begin
            n_seg.meta.phase = scmpg_pkg::PH_DECEL_DOWN;
            w_base           = w_ts;
        end else if (w_ts <= w_r) begin
            n_seg.meta.phase = scmpg_pkg::PH_JERK_UP;
            w_base           = '0;
        end else if (w_ts <= w_tb) begin
            n_seg.meta.phase = scmpg_pkg::PH_ACCEL_HOLD;
            w_base           = w_ts;
        end else if (w_ts <= w_tc) begin
            n_seg.meta.phase = scmpg_pkg::PH_JERK_DOWN;
            w_base           = w_tb;
        end else if (w_ts <= w_td) begin
            n_seg.meta.phase = scmpg_pkg::PH_CRUISE;
            w_base           = w_ts;
        end else if (w_ts <= w_te) begin
            n_seg.meta.phase = scmpg_pkg::PH_DECEL_UP;
            w_base           = w_td;
        end else if (w_ts <= w_tg) begin
            n_seg.meta.phase = scmpg_pkg::PH_DECEL_HOLD;
            w_base           = w_ts;
        end else begin
            n_seg.meta.phase = scmpg_pkg::PH_DECEL_DOWN;
            w_base           = w_tg;
        end

        // Offset into a ramp never exceeds the ramp length
        w_dt     = w_ts - w_base;
        n_seg.dt = w_dt[scmpg_pkg::DUR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tick  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_tick <= n_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_seg <= n_seg;
        end
    end

endmodule

>>> sv/scmpg_accel.sv
module scmpg_accel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scmpg_pkg::t_cfg i_cfg,
    input  logic            i_valid,
    input  scmpg_pkg::t_seg i_seg,
    input  logic            i_ready_next,
    output logic            o_ready,
    output logic            o_valid,
    output scmpg_pkg::t_acc o_acc
);

    localparam int AW = scmpg_pkg::PROD_W + 3;
    localparam logic signed [AW-1:0] ACC_MAX =
        (AW'(1) <<< (scmpg_pkg::ACC_W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] ACC_MIN = -ACC_MAX - AW'(1);

    logic                              r_s2_valid;
    scmpg_pkg::t_meta                  r_s2_meta;
    logic [scmpg_pkg::PROD_W-1:0]      r_s2_prod;
    logic                              r_s3_valid;
    scmpg_pkg::t_acc                   r_s3_acc;
    scmpg_pkg::t_acc                   n_s3_acc;
    logic                              w_ready3;
    logic                              w_load2;
    logic                              w_load3;
    logic signed [AW-1:0]              w_p;
    logic signed [AW-1:0]              w_a;
    logic signed [AW-1:0]              w_mag;
    logic signed [AW-1:0]              w_sgn;

    assign w_ready3 = !r_s3_valid || i_ready_next;
    assign o_ready  = !r_s2_valid || w_ready3;
    assign w_load2  = i_valid && o_ready;
    assign w_load3  = r_s2_valid && w_ready3;
    assign o_valid  = r_s3_valid;
    assign o_acc    = r_s3_acc;

    // Shape the acceleration from the registered jerk product, apply direction, clamp
    always_comb begin
        w_p = AW'(r_s2_prod);
        w_a = AW'(i_cfg.peak_accel);
        unique case (r_s2_meta.phase)
            scmpg_pkg::PH_JERK_UP:     w_mag = w_p;
            scmpg_pkg::PH_ACCEL_HOLD:  w_mag = w_a;
            scmpg_pkg::PH_JERK_DOWN:   w_mag = w_a - w_p;
            scmpg_pkg::PH_CRUISE:      w_mag = '0;
            scmpg_pkg::PH_DECEL_UP:    w_mag = -w_p;
            scmpg_pkg::PH_DECEL_HOLD:  w_mag = -w_a;
            scmpg_pkg::PH_DECEL_DOWN:  w_mag = w_p - w_a;
            default:                   w_mag = '0;
        endcase
        if (r_s2_meta.past_end) begin
            w_mag = '0;
        end
        w_sgn = (i_cfg.start_position > i_cfg.end_position) ? -w_mag : w_mag;

        n_s3_acc.meta = r_s2_meta;
        if (w_sgn > ACC_MAX) begin
            n_s3_acc.accel = ACC_MAX[scmpg_pkg::ACC_W-1:0];
        end else if (w_sgn < ACC_MIN) begin
            n_s3_acc.accel = ACC_MIN[scmpg_pkg::ACC_W-1:0];
        end else begin
            n_s3_acc.accel = w_sgn[scmpg_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_valid;
            end
            if (w_ready3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Jerk times ramp offset, one multiplier into its own register
    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_s2_meta <= i_seg.meta;
            r_s2_prod <= scmpg_pkg::PROD_W'(i_cfg.jerk_step) *
                         scmpg_pkg::PROD_W'(i_seg.dt);
        end
        if (w_load3) begin
            r_s3_acc <= n_s3_acc;
        end
    end

endmodule

>>> sv/scmpg_integ.sv
module scmpg_integ #(
    parameter int POS_BITS = scmpg_pkg::POS_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  scmpg_pkg::t_cfg                       i_cfg,
    input  logic                                  i_valid,
    input  scmpg_pkg::t_acc                       i_acc,
    input  logic                                  i_out_stall,
    output logic                                  o_ready,
    output logic                                  o_out_valid,
    output logic signed [scmpg_pkg::POS_W-1:0]    o_position,
    output logic signed [scmpg_pkg::VEL_W-1:0]    o_velocity,
    output logic signed [scmpg_pkg::ACC_W-1:0]    o_acceleration,
    output logic [scmpg_pkg::PHASE_W-1:0]         o_phase,
    output logic [scmpg_pkg::DUR_W-1:0]           o_tick_index,
    output logic                                  o_last
);

    localparam int VW = scmpg_pkg::VEL_W + 1;
    localparam int PE = ((POS_BITS > scmpg_pkg::POS_W) ? POS_BITS : scmpg_pkg::POS_W) + 1;
    localparam logic signed [VW-1:0] VEL_MAX =
        (VW'(1) <<< (scmpg_pkg::VEL_W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] VEL_MIN = -VEL_MAX - VW'(1);
    localparam logic signed [PE-1:0] POS_MAX = (PE'(1) <<< (POS_BITS - 1)) - PE'(1);
    localparam logic signed [PE-1:0] POS_MIN = -POS_MAX - PE'(1);

    logic signed [scmpg_pkg::VEL_W-1:0] r_vel;
    logic signed [scmpg_pkg::VEL_W-1:0] n_vel;
    logic signed [POS_BITS-1:0]         r_pos;
    logic signed [POS_BITS-1:0]         n_pos;
    logic                               r_s4_valid;
    scmpg_pkg::t_acc                    r_s4_acc;
    logic signed [POS_BITS-1:0]         r_s4_start;
    logic signed [POS_BITS-1:0]         n_s4_start;
    logic                               r_s5_valid;
    scmpg_pkg::t_acc                    r_s5_acc;
    logic signed [scmpg_pkg::VEL_W-1:0] r_s5_vel;
    logic                               w_ready5;
    logic                               w_load4;
    logic                               w_load5;
    logic signed [scmpg_pkg::VEL_W-1:0] w_vbase;
    logic signed [VW-1:0]               w_vsum;
    logic signed [PE-1:0]               w_start;
    logic signed [PE-1:0]               w_psum;
    logic signed [POS_BITS-1:0]         w_pbase;

    assign w_ready5 = !r_s5_valid || !i_out_stall;
    assign o_ready  = !r_s4_valid || w_ready5;
    assign w_load4  = i_valid && o_ready;
    assign w_load5  = r_s4_valid && w_ready5;

    // Velocity: restart clears, then add acceleration and saturate
    always_comb begin
        w_vbase = i_acc.meta.restart ? '0 : r_vel;
        w_vsum  = VW'(w_vbase) + VW'(i_acc.accel);
        if (w_vsum > VEL_MAX) begin
            n_vel = VEL_MAX[scmpg_pkg::VEL_W-1:0];
        end else if (w_vsum < VEL_MIN) begin
            n_vel = VEL_MIN[scmpg_pkg::VEL_W-1:0];
        end else begin
            n_vel = w_vsum[scmpg_pkg::VEL_W-1:0];
        end

        // Start position fitted to the accumulator range, used on restart
        w_start = PE'(i_cfg.start_position);
        if (w_start > POS_MAX) begin
            n_s4_start = POS_MAX[POS_BITS-1:0];
        end else if (w_start < POS_MIN) begin
            n_s4_start = POS_MIN[POS_BITS-1:0];
        end else begin
            n_s4_start = w_start[POS_BITS-1:0];
        end
    end

    // Position: add the new velocity to the running or restarted position
    always_comb begin
        w_pbase = r_s4_acc.meta.restart ? r_s4_start : r_pos;
        w_psum  = PE'(w_pbase) + PE'(r_vel);
        if (w_psum > POS_MAX) begin
            n_pos = POS_MAX[POS_BITS-1:0];
        end else if (w_psum < POS_MIN) begin
            n_pos = POS_MIN[POS_BITS-1:0];
        end else begin
            n_pos = w_psum[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_vel      <= '0;
            r_pos      <= '0;
        end else begin
            if (o_ready) begin
                r_s4_valid <= i_valid;
            end
            if (w_ready5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (w_load4) begin
                r_vel <= n_vel;
            end
            if (w_load5) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load4) begin
            r_s4_acc   <= i_acc;
            r_s4_start <= n_s4_start;
        end
        if (w_load5) begin
            r_s5_acc <= r_s4_acc;
            r_s5_vel <= r_vel;
        end
    end

    // Result register drives the output channel
    assign o_out_valid    = r_s5_valid;
    assign o_position     = scmpg_pkg::POS_W'(r_pos);
    assign o_velocity     = r_s5_vel;
    assign o_acceleration = r_s5_acc.accel;
    assign o_phase        = r_s5_acc.meta.phase;
    assign o_tick_index   = r_s5_acc.meta.tick_index;
    assign o_last         = r_s5_acc.meta.last;

endmodule

>>> sv/scurve_motion_profile_generator.sv
// Jerk-limited seven-segment S-curve generator for one joint. Each accepted
// input transaction produces one sample (position, velocity, acceleration,
// segment, tick number, last flag); restart=1 reloads the start position and
// begins again at tick zero. The block takes one transaction per clock while
// o_in_stall is low. Segment decode, the jerk multiplier, acceleration
// shaping, the velocity accumulator and the position accumulator each own one
// register stage. Stages move independently, so transactions keep entering
// while a finished sample waits at the output, until every stage holds a sample.
// Configuration writes are taken at any time but must be made while no sample
// is in flight; they act on the next transaction. Fixed point is 16 fraction
// bits per tick; all accumulators saturate.
module scurve_motion_profile_generator #(
    parameter int TICK_BITS = scmpg_pkg::TICK_BITS_DEF,
    parameter int POS_BITS  = scmpg_pkg::POS_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [scmpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [scmpg_pkg::POS_W-1:0]           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [scmpg_pkg::POS_W-1:0]    o_position,
    output logic signed [scmpg_pkg::VEL_W-1:0]    o_velocity,
    output logic signed [scmpg_pkg::ACC_W-1:0]    o_acceleration,
    output logic [scmpg_pkg::PHASE_W-1:0]         o_phase,
    output logic [scmpg_pkg::DUR_W-1:0]           o_tick_index,
    output logic                                  o_last
);

    scmpg_pkg::t_cfg w_cfg;
    scmpg_pkg::t_seg w_seg;
    scmpg_pkg::t_acc w_acc;
    logic            w_seg_ready;
    logic            w_seg_valid;
    logic            w_acc_ready;
    logic            w_acc_valid;
    logic            w_integ_ready;

    assign o_in_stall = !w_seg_ready;

    scmpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    scmpg_seg #(
        .TICK_BITS (TICK_BITS)
    ) u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_in_valid),
        .i_restart    (i_restart),
        .i_ready_next (w_acc_ready),
        .o_ready      (w_seg_ready),
        .o_valid      (w_seg_valid),
        .o_seg        (w_seg)
    );

    scmpg_accel u_accel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (w_seg_valid),
        .i_seg        (w_seg),
        .i_ready_next (w_integ_ready),
        .o_ready      (w_acc_ready),
        .o_valid      (w_acc_valid),
        .o_acc        (w_acc)
    );

    scmpg_integ #(
        .POS_BITS (POS_BITS)
    ) u_integ (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (w_acc_valid),
        .i_acc          (w_acc),
        .i_out_stall    (i_out_stall),
        .o_ready        (w_integ_ready),
        .o_out_valid    (o_out_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_phase        (o_phase),
        .o_tick_index   (o_tick_index),
        .o_last         (o_last)
    );

endmodule

>>> sv/scmpg_check.sv
module scmpg_check (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [scmpg_pkg::POS_W-1:0]    o_position,
    input logic signed [scmpg_pkg::ACC_W-1:0]    o_acceleration,
    input logic [scmpg_pkg::PHASE_W-1:0]         o_phase,
    input logic [scmpg_pkg::DUR_W-1:0]           o_tick_index
);

    // No sample survives a reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Input is held back only when a finished sample is stuck at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output is free");

    // Cruise carries no acceleration
    a_cruise_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase == scmpg_pkg::PH_CRUISE) |-> (o_acceleration == '0))
        else $error("nonzero acceleration while cruising");

    // A stalled sample stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled sample does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_position) && $stable(o_tick_index)))
        else $error("output payload changed while stalled");

endmodule

bind scurve_motion_profile_generator scmpg_check u_scmpg_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_position     (o_position),
    .o_acceleration (o_acceleration),
    .o_phase        (o_phase),
    .o_tick_index   (o_tick_index)
);
